// File: design/shfd_pkg.sv
`default_nettype none

package shfd_pkg;

   // Sync word and broadcast address
   localparam logic [7:0]  SYNC_A       = 8'h59;  // 'Y'
   localparam logic [7:0]  SYNC_B       = 8'h49;  // 'I'
   localparam logic [7:0]  SYNC_C       = 8'h52;  // 'R'
   localparam logic [15:0] BROADCAST_ID = 16'hFFFF;

   localparam int HEADER_BYTES = 8;
   localparam int FOOTER_BYTES = 4;

   localparam int MAX_FRAME_LEN_DEFAULT = 256;

   localparam int REQ_TDATA_W = 8;
   localparam int RSP_TDATA_W = 56;
   localparam int ADDR_W      = 16;

   typedef enum logic [3:0] {
      PH_IDLE,
      PH_GOT_A,
      PH_GOT_B,
      PH_CMD,
      PH_ID_LO,
      PH_ID_HI,
      PH_LEN_LO,
      PH_LEN_HI,
      PH_DATA
   } phase_type;

   typedef struct packed {
      logic [8:0]  frame_length;
      logic        frame_end;
      logic [15:0] slave_id;
      logic [7:0]  command;
      logic [7:0]  byte_offset;
      logic [7:0]  frame_byte;
   } result_type;

endpackage

`default_nettype wire

// File: design/sync_header_frame_deframer_core.sv
`default_nettype none

// Sync-header frame deframer.
// req_* carries received bus bytes, one per transaction. The block hunts for
// the sync word "YIR", takes command, slave id and payload length from the
// header and, for frames addressed to csr_wdata's station or to broadcast,
// puts out each payload and footer byte on rsp_* with its offset, the header
// fields and the total frame length; rsp_tlast marks the last frame byte.
// Oversize frames are dropped at the length field; frames for other stations
// are counted through but give no output.
// csr_we writes the station address; write only while the block is idle.
// A result is registered and appears on rsp_* in the cycle after its byte is accepted.
// Throughput: one byte per cycle while the output register can load; the header
// state update feeds one output register.
// Reset clears the hunt state, the address register and the output valid flag.
// When the receiver stalls, the output register holds its transaction and
// req_tready drops until the pending result is taken; bytes that produce no
// result are still accepted as long as the register can load.

module sync_header_frame_deframer_core #(
   parameter int MAX_FRAME_LEN = shfd_pkg::MAX_FRAME_LEN_DEFAULT
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_we,
   input  wire logic [shfd_pkg::ADDR_W-1:0]      csr_wdata,   // own_address
   input  wire logic                             req_tvalid,
   output      logic                             req_tready,
   input  wire logic [shfd_pkg::REQ_TDATA_W-1:0] req_tdata,   // [7:0] rx_byte
   output      logic                             rsp_tvalid,
   input  wire logic                             rsp_tready,
   // [7:0] frame_byte, [15:8] byte_offset, [23:16] command,
   // [39:24] slave_id, [48:40] frame_length, [55:49] zero
   output      logic [shfd_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   output      logic                             rsp_tlast    // frame_end
);

   logic                 load_ready;
   logic                 byte_accept;
   logic                 result_valid;
   shfd_pkg::result_type result;

   assign req_tready  = load_ready;
   assign byte_accept = req_tvalid && load_ready;

   shfd_parser #(
      .MAX_FRAME_LEN(MAX_FRAME_LEN)
   ) u_parser (
      .clock        (clock),
      .reset        (reset),
      .csr_we       (csr_we),
      .csr_wdata    (csr_wdata),
      .byte_accept  (byte_accept),
      .rx_byte      (req_tdata),
      .result_valid (result_valid),
      .result       (result)
   );

   shfd_out_reg u_out_reg (
      .clock        (clock),
      .reset        (reset),
      .result_valid (result_valid),
      .result       (result),
      .load_ready   (load_ready),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tlast    (rsp_tlast)
   );

endmodule

`default_nettype wire

// File: design/shfd_parser.sv
`default_nettype none

module shfd_parser #(
   parameter int MAX_FRAME_LEN = shfd_pkg::MAX_FRAME_LEN_DEFAULT
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        csr_we,
   input  wire logic [shfd_pkg::ADDR_W-1:0] csr_wdata,
   input  wire logic                        byte_accept,
   input  wire logic [7:0]                  rx_byte,
   output      logic                        result_valid,
   output      shfd_pkg::result_type        result
);

   localparam int RAW_W  = $clog2(MAX_FRAME_LEN + 1);
   localparam int CNT_W  = (RAW_W > 9) ? RAW_W : 9;
   localparam int TOT_W  = 17;

   shfd_pkg::phase_type phase_ff, phase_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [CNT_W-1:0]    exp_len_ff, exp_len_in;
   logic [7:0]          command_ff, command_in;
   logic [15:0]         slave_id_ff, slave_id_in;
   logic [7:0]          len_lo_ff, len_lo_in;
   logic                addressed_ff, addressed_in;
   logic [15:0]         own_addr_ff;

   logic [TOT_W-1:0]    total;
   logic [CNT_W:0]      next_count;
   logic                last;
   logic [15:0]         full_id;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= shfd_pkg::PH_IDLE;
         count_ff     <= '0;
         exp_len_ff   <= '0;
         command_ff   <= '0;
         slave_id_ff  <= '0;
         len_lo_ff    <= '0;
         addressed_ff <= 1'b0;
         own_addr_ff  <= '0;
      end else begin
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         exp_len_ff   <= exp_len_in;
         command_ff   <= command_in;
         slave_id_ff  <= slave_id_in;
         len_lo_ff    <= len_lo_in;
         addressed_ff <= addressed_in;
         if (csr_we) begin
            own_addr_ff <= csr_wdata;
         end
      end
   end

   always_comb begin
      total      = TOT_W'(shfd_pkg::HEADER_BYTES + shfd_pkg::FOOTER_BYTES)
                   + TOT_W'({rx_byte, len_lo_ff});
      next_count = {1'b0, count_ff} + (CNT_W+1)'(1);
      last       = next_count >= {1'b0, exp_len_ff};
      full_id    = {rx_byte, slave_id_ff[7:0]};

      phase_in     = phase_ff;
      count_in     = count_ff;
      exp_len_in   = exp_len_ff;
      command_in   = command_ff;
      slave_id_in  = slave_id_ff;
      len_lo_in    = len_lo_ff;
      addressed_in = addressed_ff;
      result_valid = 1'b0;

      result.frame_byte   = rx_byte;
      result.byte_offset  = count_ff[7:0];
      result.command      = command_ff;
      result.slave_id     = slave_id_ff;
      result.frame_end    = last;
      result.frame_length = exp_len_ff[8:0];

      if (byte_accept) begin
         unique case (phase_ff) inside
            shfd_pkg::PH_IDLE,
            shfd_pkg::PH_GOT_A,
            shfd_pkg::PH_GOT_B: begin
               if (phase_ff == shfd_pkg::PH_GOT_A && rx_byte == shfd_pkg::SYNC_B) begin
                  phase_in = shfd_pkg::PH_GOT_B;
                  count_in = CNT_W'(2);
               end else if (phase_ff == shfd_pkg::PH_GOT_B &&
                            rx_byte == shfd_pkg::SYNC_C) begin
                  phase_in = shfd_pkg::PH_CMD;
                  count_in = CNT_W'(3);
               end else if (rx_byte == shfd_pkg::SYNC_A) begin
                  // restart the sync word at this byte
                  phase_in = shfd_pkg::PH_GOT_A;
                  count_in = CNT_W'(1);
               end else begin
                  phase_in = shfd_pkg::PH_IDLE;
                  count_in = '0;
               end
            end
            shfd_pkg::PH_CMD: begin
               command_in = rx_byte;
               phase_in   = shfd_pkg::PH_ID_LO;
               count_in   = CNT_W'(4);
            end
            shfd_pkg::PH_ID_LO: begin
               slave_id_in = {slave_id_ff[15:8], rx_byte};
               phase_in    = shfd_pkg::PH_ID_HI;
               count_in    = CNT_W'(5);
            end
            shfd_pkg::PH_ID_HI: begin
               slave_id_in  = full_id;
               addressed_in = (full_id == own_addr_ff) ||
                              (full_id == shfd_pkg::BROADCAST_ID);
               phase_in     = shfd_pkg::PH_LEN_LO;
               count_in     = CNT_W'(6);
            end
            shfd_pkg::PH_LEN_LO: begin
               len_lo_in = rx_byte;
               phase_in  = shfd_pkg::PH_LEN_HI;
               count_in  = CNT_W'(7);
            end
            shfd_pkg::PH_LEN_HI: begin
               // drop oversize frames as soon as the length is known
               if (total <= TOT_W'(MAX_FRAME_LEN)) begin
                  exp_len_in = CNT_W'(total);
                  phase_in   = shfd_pkg::PH_DATA;
                  count_in   = CNT_W'(shfd_pkg::HEADER_BYTES);
               end else begin
                  phase_in = shfd_pkg::PH_IDLE;
                  count_in = '0;
               end
            end
            shfd_pkg::PH_DATA: begin
               result_valid = addressed_ff;
               if (last) begin
                  phase_in = shfd_pkg::PH_IDLE;
                  count_in = '0;
               end else begin
                  count_in = next_count[CNT_W-1:0];
               end
            end
            default: begin
               phase_in = shfd_pkg::PH_IDLE;
               count_in = '0;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

// File: design/shfd_out_reg.sv
`default_nettype none

module shfd_out_reg (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             result_valid,
   input  wire shfd_pkg::result_type             result,
   output      logic                             load_ready,
   output      logic                             rsp_tvalid,
   input  wire logic                             rsp_tready,
   output      logic [shfd_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   output      logic                             rsp_tlast
);

   logic                 valid_ff, valid_in;
   shfd_pkg::result_type data_ff, data_in;

   // the register may take a new transaction whenever it is empty or draining
   assign load_ready = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (load_ready) begin
         valid_in = result_valid;
         data_in  = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tlast  = data_ff.frame_end;
   assign rsp_tdata  = {7'b0,
                        data_ff.frame_length,
                        data_ff.slave_id,
                        data_ff.command,
                        data_ff.byte_offset,
                        data_ff.frame_byte};

endmodule

`default_nettype wire

// File: design/shfd_checker.sv
`default_nettype none

module shfd_checker (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             req_tvalid,
   input wire logic                             req_tready,
   input wire logic                             rsp_tvalid,
   input wire logic                             rsp_tready,
   input wire logic [shfd_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input wire logic                             rsp_tlast
);

   // reset empties the output register
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result pending after reset");

   // a new result only follows an accepted byte
   a_result_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready))
      else $error("result without accepted byte");

   // the last byte sits at frame_length - 1
   a_last_offset: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |->
         (8'(rsp_tdata[15:8] + 8'd1) == rsp_tdata[47:40]))
      else $error("frame end at wrong offset");

   // hold a stalled transaction
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=>
         (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast)))
      else $error("stalled result changed");

endmodule

bind sync_header_frame_deframer_core shfd_checker u_shfd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire

// File: sim/sync_header_frame_deframer_core_tb.sv
`default_nettype none

module sync_header_frame_deframer_core_tb;
   import shfd_pkg::*;

   localparam int FRAME_LIMIT   = MAX_FRAME_LEN_DEFAULT;
   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int SETTLE_CYCLES = 4;
   localparam int PHASE_BYTES   = 480;
   localparam int HOLD_CYCLES   = 250;
   localparam int PRINT_CAP     = 40;

   typedef struct packed {
      logic [7:0]  frame_byte;
      logic [7:0]  byte_offset;
      logic [7:0]  command;
      logic [15:0] slave_id;
      logic        frame_end;
      logic [8:0]  frame_length;
   } frame_out_t;

   // How a directed row gets its expectation: none, typed in, or from the predictor
   typedef enum logic [1:0] {
      ROW_NONE,
      ROW_RESULT,
      ROW_PREDICT
   } row_kind_e;

   typedef struct packed {
      logic [7:0] rx;
      row_kind_e  kind;
      frame_out_t want;
   } stim_row_t;

   localparam frame_out_t NO_OUT = '0;
   localparam int DIRECTED_ROWS = 25;
   localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
      '{8'h00, ROW_NONE,   NO_OUT},                                        // stray byte
      '{SYNC_A, ROW_NONE,  NO_OUT},
      '{SYNC_B, ROW_NONE,  NO_OUT},
      '{SYNC_C, ROW_NONE,  NO_OUT},
      '{8'hFF, ROW_NONE,   NO_OUT},                                        // command
      '{8'h00, ROW_NONE,   NO_OUT},                                        // id low
      '{8'h00, ROW_NONE,   NO_OUT},                                        // id high: own
      '{8'h00, ROW_NONE,   NO_OUT},                                        // empty payload
      '{8'h00, ROW_NONE,   NO_OUT},
      '{8'h00, ROW_RESULT, '{8'h00, 8'd8,  8'hFF, 16'h0000, 1'b0, 9'd12}},
      '{8'hFF, ROW_RESULT, '{8'hFF, 8'd9,  8'hFF, 16'h0000, 1'b0, 9'd12}},
      '{SYNC_A, ROW_RESULT, '{SYNC_A, 8'd10, 8'hFF, 16'h0000, 1'b0, 9'd12}}, // plain data
      '{8'h80, ROW_RESULT, '{8'h80, 8'd11, 8'hFF, 16'h0000, 1'b1, 9'd12}},
      '{SYNC_A, ROW_PREDICT, NO_OUT},
      '{SYNC_A, ROW_PREDICT, NO_OUT},                                      // restart on 'Y'
      '{SYNC_B, ROW_PREDICT, NO_OUT},
      '{SYNC_C, ROW_PREDICT, NO_OUT},
      '{8'h01, ROW_NONE,   NO_OUT},
      '{8'h00, ROW_NONE,   NO_OUT},
      '{8'h00, ROW_NONE,   NO_OUT},
      '{8'hFF, ROW_NONE,   NO_OUT},                                        // largest length
      '{8'hFF, ROW_NONE,   NO_OUT},
      '{SYNC_A, ROW_NONE,  NO_OUT},
      '{SYNC_B, ROW_NONE,  NO_OUT},
      '{8'h00, ROW_NONE,   NO_OUT}                                         // 'R' missing
   };

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   csr_we     = 1'b0;
   logic [ADDR_W-1:0]      csr_wdata  = '0;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tlast;

   sync_header_frame_deframer_core #(
      .MAX_FRAME_LEN(FRAME_LIMIT)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Deframer state as the predictor sees it
   phase_type   rx_phase    = PH_IDLE;
   int unsigned rx_count    = 0;
   int unsigned frame_total = 0;
   logic [7:0]  held_cmd    = '0;
   logic [15:0] held_id     = '0;
   logic [7:0]  len_low     = '0;
   bit          addressed   = 1'b0;
   logic [15:0] station     = '0;

   frame_out_t pending_frame_bytes[$];

   int errors           = 0;
   int cycle_count      = 0;
   int bytes_fed        = 0;
   int noise_bytes      = 0;
   int outputs_checked  = 0;
   int frames_delivered = 0;
   int oversize_drops   = 0;
   int station_writes   = 0;
   int send_calm        = 0;
   int recv_calm        = 0;
   int stall_left       = 0;
   int hold_left        = 0;

   task automatic report(input string what);
      errors++;
      if (errors <= PRINT_CAP) $display("ERROR t=%0t: %s", $time, what);
   endtask

   function automatic void restart_hunt(input logic [7:0] b);
      rx_phase = (b == SYNC_A) ? PH_GOT_A : PH_IDLE;
   endfunction

   function automatic bit deframe_byte(input logic [7:0] b, output frame_out_t o);
      int unsigned total;
      int unsigned offset;
      bit          last;
      o = '0;
      case (rx_phase)
         PH_GOT_A: begin
            if (b == SYNC_B) rx_phase = PH_GOT_B;
            else restart_hunt(b);
         end
         PH_GOT_B: begin
            if (b == SYNC_C) rx_phase = PH_CMD;
            else restart_hunt(b);
         end
         PH_CMD: begin
            held_cmd = b;
            rx_phase = PH_ID_LO;
         end
         PH_ID_LO: begin
            held_id  = {8'h00, b};
            rx_phase = PH_ID_HI;
         end
         PH_ID_HI: begin
            held_id   = {b, held_id[7:0]};
            addressed = (held_id == station) || (held_id == BROADCAST_ID);
            rx_phase  = PH_LEN_LO;
         end
         PH_LEN_LO: begin
            len_low  = b;
            rx_phase = PH_LEN_HI;
         end
         PH_LEN_HI: begin
            total    = HEADER_BYTES + FOOTER_BYTES + {b, len_low};
            rx_count = HEADER_BYTES;
            if (total <= FRAME_LIMIT) begin
               frame_total = total;
               rx_phase    = PH_DATA;
            end else begin
               rx_phase = PH_IDLE;
               oversize_drops++;
            end
         end
         PH_DATA: begin
            offset   = rx_count;
            rx_count = rx_count + 1;
            last     = rx_count >= frame_total;
            if (last) rx_phase = PH_IDLE;
            if (addressed) begin
               o = '{frame_byte: b, byte_offset: offset[7:0], command: held_cmd,
                     slave_id: held_id, frame_end: last, frame_length: frame_total[8:0]};
               if (last) frames_delivered++;
               return 1'b1;
            end
         end
         default: restart_hunt(b);
      endcase
      return 1'b0;
   endfunction

   // Mostly no pause, some short, a few long; now and then a calm stretch
   function automatic int pick_pause(inout int calm_left);
      int r;
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 3) begin
         calm_left = $urandom_range(40, 120);
         return 0;
      end
      if (r < 65) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [7:0] rand_data_byte();
      if ($urandom_range(0, 9) == 0) begin
         case ($urandom_range(0, 2))
            0:       return SYNC_A;
            1:       return SYNC_B;
            default: return SYNC_C;
         endcase
      end
      return 8'($urandom);
   endfunction

   task automatic send_byte(input logic [7:0] b, input row_kind_e kind, input frame_out_t want);
      int         gap;
      frame_out_t o;
      bit         hit;
      gap = pick_pause(send_calm);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
      hit = deframe_byte(b, o);
      case (kind)
         ROW_RESULT:  pending_frame_bytes.push_back(want);
         ROW_PREDICT: if (hit) pending_frame_bytes.push_back(o);
         default: ;
      endcase
      bytes_fed++;
      @(negedge clock);
   endtask

   task automatic set_station(input logic [15:0] a);
      csr_we    <= 1'b1;
      csr_wdata <= a;
      @(negedge clock);
      csr_we    <= 1'b0;
      station    = a;
      station_writes++;
   endtask

   // Hold the input until every output byte has come back, then let the block settle
   task automatic drain_and_settle();
      req_tvalid <= 1'b0;
      while (pending_frame_bytes.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic run_traffic(input int target);
      int          start;
      int          pick;
      int          r;
      int          n;
      int          i;
      bit          oversize;
      logic [7:0]  cmd;
      logic [15:0] id;
      logic [15:0] plen;
      start = bytes_fed - noise_bytes;
      while (bytes_fed - noise_bytes - start < target) begin
         pick = $urandom_range(0, 99);
         if (pick < 8) begin
            n = $urandom_range(1, 6);
            noise_bytes += n;
            repeat (n) send_byte(rand_data_byte(), ROW_PREDICT, NO_OUT);
         end else if (pick < 16) begin
            // broken sync word
            send_byte(SYNC_A, ROW_PREDICT, NO_OUT);
            if ($urandom_range(0, 1)) send_byte(SYNC_B, ROW_PREDICT, NO_OUT);
            send_byte(8'($urandom), ROW_PREDICT, NO_OUT);
         end else begin
            oversize = pick < 28;
            r = $urandom_range(0, 99);
            cmd = (r < 10) ? 8'h00 : (r < 20) ? 8'hFF : 8'($urandom);
            r = $urandom_range(0, 99);
            if (r < 45)      id = station;
            else if (r < 65) id = BROADCAST_ID;
            else if (r < 80) id = station ^ (16'h0001 << $urandom_range(0, 15));
            else             id = 16'($urandom);
            r = $urandom_range(0, 99);
            if (oversize) begin
               if (r < 30)      plen = 16'(FRAME_LIMIT - HEADER_BYTES - FOOTER_BYTES + 1);
               else if (r < 50) plen = 16'hFFFF;
               else plen = 16'($urandom_range(FRAME_LIMIT - HEADER_BYTES - FOOTER_BYTES + 1,
                                               16'hFFFF));
            end else begin
               if (r < 70)      plen = 16'($urandom_range(0, 16));
               else if (r < 95) plen = 16'($urandom_range(17, 60));
               else if (r < 98) plen = 16'($urandom_range(61, 243));
               else             plen = 16'(FRAME_LIMIT - HEADER_BYTES - FOOTER_BYTES);
            end
            if ($urandom_range(0, 6) == 0) send_byte(SYNC_A, ROW_PREDICT, NO_OUT);
            send_byte(SYNC_A, ROW_PREDICT, NO_OUT);
            send_byte(SYNC_B, ROW_PREDICT, NO_OUT);
            send_byte(SYNC_C, ROW_PREDICT, NO_OUT);
            send_byte(cmd, ROW_PREDICT, NO_OUT);
            send_byte(id[7:0], ROW_PREDICT, NO_OUT);
            send_byte(id[15:8], ROW_PREDICT, NO_OUT);
            send_byte(plen[7:0], ROW_PREDICT, NO_OUT);
            send_byte(plen[15:8], ROW_PREDICT, NO_OUT);
            if (!oversize) begin
               for (i = 0; i < int'(plen) + FOOTER_BYTES; i++)
                  send_byte(rand_data_byte(), ROW_PREDICT, NO_OUT);
            end
         end
      end
   endtask

   // Receiver: random stalls, plus a long hold-off when requested
   initial begin
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
            stall_left = pick_pause(recv_calm);
         end
      end
   end

   always @(posedge clock) begin : check_output
      frame_out_t want;
      frame_out_t got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '{frame_byte: rsp_tdata[7:0], byte_offset: rsp_tdata[15:8],
                 command: rsp_tdata[23:16], slave_id: rsp_tdata[39:24],
                 frame_end: rsp_tlast, frame_length: rsp_tdata[48:40]};
         if (pending_frame_bytes.size() == 0) begin
            report($sformatf("output byte %02h at offset %0d with nothing expected",
                             got.frame_byte, got.byte_offset));
         end else begin
            want = pending_frame_bytes.pop_front();
            outputs_checked++;
            if (got.frame_byte !== want.frame_byte)
               report($sformatf("frame_byte want %02h got %02h", want.frame_byte, got.frame_byte));
            if (got.byte_offset !== want.byte_offset)
               report($sformatf("byte_offset want %0d got %0d", want.byte_offset, got.byte_offset));
            if (got.command !== want.command)
               report($sformatf("command want %02h got %02h", want.command, got.command));
            if (got.slave_id !== want.slave_id)
               report($sformatf("slave_id want %04h got %04h", want.slave_id, got.slave_id));
            if (got.frame_end !== want.frame_end)
               report($sformatf("frame_end want %0b got %0b", want.frame_end, got.frame_end));
            if (got.frame_length !== want.frame_length)
               report($sformatf("frame_length want %0d got %0d",
                                want.frame_length, got.frame_length));
            if (rsp_tdata[55:49] !== '0)
               report($sformatf("padding bits not zero: %02h", rsp_tdata[55:49]));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d output bytes outstanding",
                  cycle_count, pending_frame_bytes.size());
         $display("simulation failed");
         $finish;
      end
   end

   initial begin : stimulus
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      for (int r = 0; r < DIRECTED_ROWS; r++)
         send_byte(DIRECTED[r].rx, DIRECTED[r].kind, DIRECTED[r].want);
      drain_and_settle();
      for (int p = 0; p < 4; p++) begin
         case (p)
            0:       set_station(16'($urandom_range(1, 16'hFFFE)));
            1:       set_station(BROADCAST_ID);
            2:       set_station(16'h0000);
            default: set_station(16'($urandom));
         endcase
         // keep the sender going while the receiver holds off
         if (p == 0 || p == 2) hold_left = HOLD_CYCLES;
         run_traffic(PHASE_BYTES);
         drain_and_settle();
      end
      $display("fed %0d bytes (%0d of them stray), checked %0d output bytes",
               bytes_fed, noise_bytes, outputs_checked);
      $display("%0d frames delivered, %0d oversize frames dropped, %0d address writes",
               frames_delivered, oversize_drops, station_writes);
      if (errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
